// ----- rtl/mpws_pkg.sv -----
`timescale 1ns / 1ps

package mpws_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int CFG_W     = 8;
	localparam int CFG_IDX_W = 1;
	localparam int MIN_SUM_W = 23;
	localparam int SUM_SAT   = 4194303;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_LEN = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN = 1'b1;

	localparam logic [CFG_W-1:0] MIN_LEN_RST = 8'd1;
	localparam logic [CFG_W-1:0] MAX_LEN_RST = 8'd128;

	// per-cycle control broadcast to every cell
	typedef struct packed {
		logic load;
		logic last;
		logic shift;
	} cell_ctrl_t;

	// drain status from the tail reducer
	typedef struct packed {
		logic busy;
		logic shift;
	} drain_t;

endpackage

// ----- rtl/mpws_channels.sv -----
`timescale 1ns / 1ps

interface mpws_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [mpws_pkg::SAMPLE_W-1:0] sample;
	logic                                 last;

	modport source (output valid, sample, last, input ready);
	modport sink (input valid, sample, last, output ready);
endinterface

interface mpws_out_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [mpws_pkg::MIN_SUM_W-1:0] min_sum;
	logic                                  found;

	modport source (output valid, min_sum, found, input ready);
	modport sink (input valid, min_sum, found, output ready);
endinterface

// ----- rtl/mpws_cell.sv -----
`timescale 1ns / 1ps

module mpws_cell #(
	parameter int MAX_WINDOW = 128,
	parameter int LEN        = 1
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  mpws_pkg::cell_ctrl_t                 ctrl,
	input  logic signed [mpws_pkg::SAMPLE_W-1:0] sample,
	input  logic [mpws_pkg::CFG_W-1:0]           min_len,
	input  logic [mpws_pkg::CFG_W-1:0]           max_len,
	input  logic signed [mpws_pkg::SAMPLE_W+$clog2(MAX_WINDOW)-1:0] prev_sum,
	input  logic                                 prev_valid,
	input  logic signed [mpws_pkg::SAMPLE_W+$clog2(MAX_WINDOW)-1:0] prev_best,
	input  logic                                 prev_have,
	output logic signed [mpws_pkg::SAMPLE_W+$clog2(MAX_WINDOW)-1:0] sum,
	output logic                                 valid,
	output logic signed [mpws_pkg::SAMPLE_W+$clog2(MAX_WINDOW)-1:0] best,
	output logic                                 have
);

	localparam int SUM_W = mpws_pkg::SAMPLE_W + $clog2(MAX_WINDOW);
	localparam int LEN_W = $clog2(MAX_WINDOW + 1);
	localparam int CMP_W = (LEN_W > mpws_pkg::CFG_W) ? LEN_W : mpws_pkg::CFG_W;
	localparam logic [CMP_W-1:0] LEN_C = CMP_W'(LEN);

	logic signed [SUM_W-1:0] sum_q;
	logic signed [SUM_W-1:0] best_q;
	logic                    valid_q;
	logic                    have_q;

	logic signed [SUM_W-1:0] new_sum;
	logic [CMP_W-1:0]        lo;
	logic [CMP_W-1:0]        hi;
	logic                    in_range;
	logic                    better;

	assign new_sum  = prev_sum + SUM_W'(sample);
	assign lo       = (min_len == '0) ? CMP_W'(1) : CMP_W'(min_len);
	assign hi       = CMP_W'(max_len);
	assign in_range = (LEN_C >= lo) && (LEN_C <= hi);
	assign better   = prev_valid && in_range && (new_sum > 0) &&
		(!have_q || (new_sum < best_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			have_q  <= 1'b0;
		end else if (ctrl.load) begin
			valid_q <= ctrl.last ? 1'b0 : prev_valid;
			if (better)
				have_q <= 1'b1;
		end else if (ctrl.shift) begin
			have_q <= prev_have;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			sum_q <= new_sum;
			if (better)
				best_q <= new_sum;
		end else if (ctrl.shift) begin
			best_q <= prev_best;
		end
	end

	assign sum   = sum_q;
	assign valid = valid_q;
	assign best  = best_q;
	assign have  = have_q;

endmodule

// ----- rtl/mpws_reduce.sv -----
`timescale 1ns / 1ps

module mpws_reduce #(
	parameter int MAX_WINDOW = 128
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [mpws_pkg::SAMPLE_W+$clog2(MAX_WINDOW)-1:0] tail_best,
	input  logic                    tail_have,
	output mpws_pkg::drain_t        drain,
	mpws_out_if.source              results
);

	localparam int SUM_W = mpws_pkg::SAMPLE_W + $clog2(MAX_WINDOW);
	localparam int CNT_W = $clog2(MAX_WINDOW + 1);
	localparam int EXT_W = (SUM_W > mpws_pkg::MIN_SUM_W) ? SUM_W : mpws_pkg::MIN_SUM_W + 1;
	localparam logic [CNT_W-1:0] CNT_END = CNT_W'(MAX_WINDOW);
	localparam logic signed [EXT_W-1:0] SAT = EXT_W'(mpws_pkg::SUM_SAT);

	logic [CNT_W-1:0]        cnt_q;
	logic                    busy_q;
	logic signed [SUM_W-1:0] acc_q;
	logic                    acc_have_q;
	logic                    out_valid_q;
	logic signed [mpws_pkg::MIN_SUM_W-1:0] min_sum_q;
	logic                    found_q;

	logic                    shift;
	logic                    finish;
	logic                    take;
	logic signed [EXT_W-1:0] acc_ext;
	logic signed [mpws_pkg::MIN_SUM_W-1:0] sat_sum;

	assign shift   = busy_q && (cnt_q != CNT_END);
	assign finish  = busy_q && !shift && (!out_valid_q || results.ready);
	assign take    = tail_have && (!acc_have_q || (tail_best < acc_q));
	assign acc_ext = EXT_W'(acc_q);
	assign sat_sum = (acc_ext > SAT) ? mpws_pkg::MIN_SUM_W'(mpws_pkg::SUM_SAT) :
		acc_ext[mpws_pkg::MIN_SUM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cnt_q       <= '0;
			acc_have_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (finish)
				out_valid_q <= 1'b1;
			else if (results.valid && results.ready)
				out_valid_q <= 1'b0;
			if (start) begin
				busy_q     <= 1'b1;
				cnt_q      <= '0;
				acc_have_q <= 1'b0;
			end else if (shift) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (take)
					acc_have_q <= 1'b1;
			end else if (finish) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (shift && take)
			acc_q <= tail_best;
		if (finish) begin
			min_sum_q <= acc_have_q ? sat_sum : '1;
			found_q   <= acc_have_q;
		end
	end

	assign drain.busy      = busy_q;
	assign drain.shift     = shift;
	assign results.valid   = out_valid_q;
	assign results.min_sum = min_sum_q;
	assign results.found   = found_q;

endmodule

// ----- rtl/min_positive_window_sum_core.sv -----
// one sample transaction per cycle within a batch, each cell updating its window sum
// a last-flagged transaction starts a drain that shifts the cell bests through the tail compare
// the result is registered after the drain, once the output is free; input ready is low
// until then, and stays low while an earlier result has not been taken
// reset clears cell flags, drain state and output valid; min_len = 1, max_len = 128
`timescale 1ns / 1ps

module min_positive_window_sum_core #(
	parameter int MAX_WINDOW = 128
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mpws_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mpws_pkg::CFG_W-1:0]        cfg_wdata,
	mpws_in_if.sink                           samples,
	mpws_out_if.source                        results
);

	localparam int SUM_W = mpws_pkg::SAMPLE_W + $clog2(MAX_WINDOW);

	logic [mpws_pkg::CFG_W-1:0] min_len_q;
	logic [mpws_pkg::CFG_W-1:0] max_len_q;

	mpws_pkg::cell_ctrl_t ctrl;
	mpws_pkg::drain_t     drain;

	logic signed [SUM_W-1:0] sum_c   [MAX_WINDOW+1];
	logic                    valid_c [MAX_WINDOW+1];
	logic signed [SUM_W-1:0] best_c  [MAX_WINDOW+1];
	logic                    have_c  [MAX_WINDOW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len_q <= mpws_pkg::MIN_LEN_RST;
			max_len_q <= mpws_pkg::MAX_LEN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				mpws_pkg::REG_MIN_LEN: min_len_q <= cfg_wdata;
				mpws_pkg::REG_MAX_LEN: max_len_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign samples.ready = !drain.busy;
	assign ctrl.load     = samples.valid && samples.ready;
	assign ctrl.last     = samples.last;
	assign ctrl.shift    = drain.shift;

	// head of the chain
	assign sum_c[0]   = '0;
	assign valid_c[0] = 1'b1;
	assign best_c[0]  = '0;
	assign have_c[0]  = 1'b0;

	for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
		mpws_cell #(
			.MAX_WINDOW (MAX_WINDOW),
			.LEN        (k + 1)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.sample     (samples.sample),
			.min_len    (min_len_q),
			.max_len    (max_len_q),
			.prev_sum   (sum_c[k]),
			.prev_valid (valid_c[k]),
			.prev_best  (best_c[k]),
			.prev_have  (have_c[k]),
			.sum        (sum_c[k+1]),
			.valid      (valid_c[k+1]),
			.best       (best_c[k+1]),
			.have       (have_c[k+1])
		);
	end

	mpws_reduce #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_reduce (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (ctrl.load && ctrl.last),
		.tail_best (best_c[MAX_WINDOW]),
		.tail_have (have_c[MAX_WINDOW]),
		.drain     (drain),
		.results   (results)
	);

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;

	localparam int WIN        = 128;
	localparam int ITEM_GOAL  = 650;
	localparam int LIMIT      = 600000;

	typedef logic [mpws_pkg::SAMPLE_W-1:0] sample_t;
	typedef logic [mpws_pkg::CFG_W-1:0]    cfg_t;

	typedef struct packed {
		logic signed [mpws_pkg::MIN_SUM_W-1:0] min_sum;
		logic                                  found;
	} minimum_t;

	class min_sum_tracker;
		int       sums[WIN];
		int       seen;
		int       best;
		bit       have_best;
		int       min_len;
		int       max_len;
		minimum_t expected_minima[$];
		int       errors;
		int       items;

		function new();
			clear_batch();
			min_len = int'(mpws_pkg::MIN_LEN_RST);
			max_len = int'(mpws_pkg::MAX_LEN_RST);
			errors  = 0;
			items   = 0;
		endfunction

		function void clear_batch();
			foreach (sums[k])
				sums[k] = 0;
			seen      = 0;
			best      = 0;
			have_best = 0;
		endfunction

		function void set_reg(logic [mpws_pkg::CFG_IDX_W-1:0] idx, cfg_t val);
			if (idx == mpws_pkg::REG_MIN_LEN)
				min_len = int'(val);
			else if (idx == mpws_pkg::REG_MAX_LEN)
				max_len = int'(val);
		endfunction

		function void note_sample(logic signed [mpws_pkg::SAMPLE_W-1:0] s, logic is_last);
			int       lo;
			int       hi;
			int       v;
			minimum_t m;
			items++;
			for (int k = WIN - 1; k > 0; k--)
				sums[k] = sums[k-1] + int'(s);
			sums[0] = int'(s);
			if (seen < WIN)
				seen++;
			lo = (min_len == 0) ? 1 : min_len;
			hi = max_len;
			if (hi > WIN)
				hi = WIN;
			if (hi > seen)
				hi = seen;
			for (int len = lo; len <= hi; len++) begin
				v = sums[len-1];
				if (v > 0 && (!have_best || v < best)) begin
					best      = v;
					have_best = 1;
				end
			end
			if (is_last) begin
				if (have_best) begin
					v         = (best > mpws_pkg::SUM_SAT) ? mpws_pkg::SUM_SAT : best;
					m.min_sum = v[mpws_pkg::MIN_SUM_W-1:0];
					m.found   = 1'b1;
				end else begin
					m.min_sum = '1;
					m.found   = 1'b0;
				end
				expected_minima.push_back(m);
				clear_batch();
			end
		endfunction

		function void check_minimum(logic signed [mpws_pkg::MIN_SUM_W-1:0] min_sum,
			logic found);
			minimum_t m;
			if (expected_minima.size() == 0) begin
				$display("%0t: unexpected result min_sum=%0d found=%0b", $time, min_sum, found);
				errors++;
				return;
			end
			m = expected_minima.pop_front();
			if (min_sum !== m.min_sum) begin
				$display("%0t: min_sum mismatch expected=%0d actual=%0d",
					$time, m.min_sum, min_sum);
				errors++;
			end
			if (found !== m.found) begin
				$display("%0t: found mismatch expected=%0b actual=%0b", $time, m.found, found);
				errors++;
			end
		endfunction

		function int pending();
			return expected_minima.size();
		endfunction
	endclass

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [mpws_pkg::CFG_IDX_W-1:0] cfg_index;
	cfg_t                           cfg_wdata;
	int                             cycle_cnt = 0;
	int                             ready_mode = 0;
	min_sum_tracker                 sb;

	mpws_in_if  samples();
	mpws_out_if results();

	min_positive_window_sum_core #(
		.MAX_WINDOW(WIN)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.samples  (samples),
		.results  (results)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// transaction monitors
	always @(posedge clk) begin
		if (arst_n && samples.valid && samples.ready)
			sb.note_sample(samples.sample, samples.last);
		if (arst_n && results.valid && results.ready)
			sb.check_minimum(results.min_sum, results.found);
	end

	// result backpressure
	always @(posedge clk) begin
		int r;
		r = $urandom_range(0, 99);
		if ($urandom_range(0, 63) == 0)
			ready_mode <= $urandom_range(0, 2);
		case (ready_mode)
			0: results.ready <= 1'b1;
			1: results.ready <= (r < 70);
			default: results.ready <= (r < 15);
		endcase
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	function automatic sample_t pick_sample(int style);
		int r;
		r = $urandom_range(0, 99);
		case (style)
			0: return sample_t'($urandom_range(0, 65535));
			1: return sample_t'($urandom_range(0, 16) - 8);
			2: return (r < 85) ? sample_t'(-$urandom_range(1, 32768)) :
				sample_t'($urandom_range(1, 40));
			3: begin
				case (r % 6)
					0: return 16'sh7fff;
					1: return 16'sh8000;
					2: return 16'sd0;
					3: return 16'sd1;
					4: return -16'sd1;
					default: return sample_t'($urandom_range(0, 65535));
				endcase
			end
			default: return sample_t'($urandom_range(0, 200) - 100);
		endcase
	endfunction

	task automatic send_sample(sample_t s, logic is_last, bit no_gap);
		int gap;
		samples.valid  <= 1'b1;
		samples.sample <= s;
		samples.last   <= is_last;
		do @(posedge clk); while (samples.ready !== 1'b1);
		gap = no_gap ? 0 : pick_gap();
		if (gap > 0) begin
			samples.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_batch(int len, int style, bit burst);
		for (int i = 0; i < len; i++)
			send_sample(pick_sample(style), i == len - 1, burst);
	endtask

	task automatic drain();
		samples.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() > 0)
			@(posedge clk);
		repeat (WIN + 10) @(posedge clk);
	endtask

	task automatic set_lengths(cfg_t min_len, cfg_t max_len);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= mpws_pkg::REG_MIN_LEN;
		cfg_wdata <= min_len;
		@(posedge clk);
		sb.set_reg(mpws_pkg::REG_MIN_LEN, min_len);
		cfg_index <= mpws_pkg::REG_MAX_LEN;
		cfg_wdata <= max_len;
		@(posedge clk);
		sb.set_reg(mpws_pkg::REG_MAX_LEN, max_len);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		int n_batches;
		int len;
		clk            = 1'b0;
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = '0;
		cfg_wdata      = '0;
		samples.valid  = 1'b0;
		samples.sample = '0;
		samples.last   = 1'b0;
		sb             = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults after reset
		send_sample(16'sh7fff, 1'b1, 0);
		send_sample(16'sh8000, 1'b1, 0);
		send_sample(16'sd0, 1'b1, 0);
		send_sample(16'sd5, 1'b0, 0);
		send_sample(-16'sd5, 1'b0, 0);
		send_sample(16'sd3, 1'b1, 0);
		send_sample(16'sh8000, 1'b0, 1);
		send_sample(16'sh7fff, 1'b1, 1);
		send_sample(16'sd1, 1'b0, 0);
		send_sample(-16'sd1, 1'b0, 0);
		send_sample(16'sd1, 1'b0, 0);
		send_sample(-16'sd1, 1'b1, 0);
		send_sample(-16'sd1, 1'b0, 0);
		send_sample(-16'sd2, 1'b1, 0);
		send_sample(16'sh7fff, 1'b0, 0);
		send_sample(16'sh7fff, 1'b0, 0);
		send_sample(16'sh8000, 1'b0, 0);
		send_sample(16'sd2, 1'b1, 0);

		// zero minimum, maximum beyond the window
		set_lengths(8'd0, 8'd255);
		send_sample(16'sd4, 1'b0, 0);
		send_sample(-16'sd3, 1'b1, 0);
		send_batch(6, 1, 1);

		// full window only, output just below its top
		set_lengths(8'd128, 8'd128);
		send_batch(128, 3, 1);
		for (int i = 0; i < WIN; i++)
			send_sample(16'sh7fff, i == WIN - 1, i % 7 != 0);
		send_batch(140, 4, 0);

		// crossed limits, and equal limits
		set_lengths(8'd5, 8'd3);
		send_batch(8, 4, 0);
		set_lengths(8'd1, 8'd1);
		send_batch(5, 1, 0);
		set_lengths(8'd255, 8'd0);
		send_batch(4, 3, 0);

		while (sb.items < ITEM_GOAL) begin
			if ($urandom_range(0, 3) == 0)
				set_lengths(cfg_t'($urandom_range(0, 255)), cfg_t'($urandom_range(0, 255)));
			else begin
				len = $urandom_range(0, 10);
				set_lengths(cfg_t'(len), cfg_t'(len + $urandom_range(0, 20)));
			end
			n_batches = $urandom_range(3, 8);
			for (int b = 0; b < n_batches; b++) begin
				len = ($urandom_range(0, 99) < 95) ? $urandom_range(1, 16)
					: $urandom_range(100, 140);
				send_batch(len, $urandom_range(0, 4), $urandom_range(0, 3) == 0);
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
